// ===== rtl/udpf_pkg.sv =====
// shared types and constants for the udp/ipv4/ethernet transmit framer
`timescale 1ns / 1ps

package udpf_pkg;

   localparam int MaxPayload = 1458;
   localparam int HdrLen     = 42;
   localparam int HdrIdxW    = $clog2(HdrLen + 1);
   localparam int LenW       = 11;
   localparam int CsrIdxW    = 3;
   localparam int CsrDataW   = 48;

   localparam logic [15:0] EtherTypeIpv4 = 16'h0800;
   localparam logic [7:0]  VerIhl        = 8'h45;
   localparam logic [7:0]  IpTtl         = 8'd64;
   localparam logic [7:0]  IpProtoUdp    = 8'd17;
   localparam logic [15:0] IpHdrBytes    = 16'd28;
   localparam logic [15:0] UdpHdrBytes   = 16'd8;

   localparam logic [47:0] SourceMacReset      = 48'h749050B0DD2A;
   localparam logic [47:0] DestinationMacReset = 48'h00E04C680324;
   localparam logic [31:0] SourceIpReset       = 32'hC0A88905;
   localparam logic [31:0] DestinationIpReset  = 32'hC0A88901;
   localparam logic [15:0] SourcePortReset     = 16'd12345;
   localparam logic [15:0] DestinationPortReset = 16'd12345;

   typedef enum logic [CsrIdxW-1:0] {
      RegSourceMac      = 3'd0,
      RegDestinationMac = 3'd1,
      RegSourceIp       = 3'd2,
      RegDestinationIp  = 3'd3,
      RegSourcePort     = 3'd4,
      RegDestinationPort = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [47:0] source_mac;
      logic [47:0] destination_mac;
      logic [31:0] source_ip;
      logic [31:0] destination_ip;
      logic [15:0] source_port;
      logic [15:0] destination_port;
   } cfg_type;

endpackage

// ===== rtl/udp_ipv4_ethernet_tx_framer_core.sv =====
// top level of the udp/ipv4/ethernet ii transmit framer
// a payload item is registered when accepted and its result reaches rsp through the output register
// a start item with a good length yields 43 result items, one per cycle unless rsp_tready stalls,
// and holds req_tready low until the last of them; a start item with a bad length yields one
// error item; outside header insertion one payload byte passes per cycle unless rsp_tready stalls;
// results leave through an output register so a new item is taken while the last result waits
// synchronous reset clears the pipeline and frame state and restores default addresses and ports
`timescale 1ns / 1ps

module udp_ipv4_ethernet_tx_framer_core (
   input  logic                          clock,
   input  logic                          reset,
   // item input
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [23:0]                   req_tdata,  // payload_byte[7:0], payload_length[18:8]
   input  logic                          req_tuser,  // frame_start
   // result output
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [7:0]                    rsp_tdata,  // frame_byte[7:0]
   output logic                          rsp_tlast,
   output logic                          rsp_tuser,  // length_error
   // configuration writes
   input  logic                          csr_wr_en,
   input  logic [udpf_pkg::CsrIdxW-1:0]  csr_index,
   input  logic [udpf_pkg::CsrDataW-1:0] csr_wr_data
);
   import udpf_pkg::*;

   cfg_type              cfg_ff, cfg_in;

   logic                 in_valid_ff, in_valid_in;
   logic [7:0]           in_byte_ff, in_byte_in;
   logic                 in_start_ff, in_start_in;
   logic [LenW-1:0]      in_len_ff, in_len_in;

   logic [HdrIdxW-1:0]   hdr_idx_ff, hdr_idx_in;
   logic [LenW-1:0]      rem_ff, rem_in;
   logic                 drop_ff, drop_in;

   logic                 out_valid_ff, out_valid_in;
   logic [7:0]           out_byte_ff, out_byte_in;
   logic                 out_last_ff, out_last_in;
   logic                 out_err_ff, out_err_in;

   logic                 hdr_byte;
   logic [7:0]           hdr_data;
   logic                 len_bad;
   logic                 good_start;
   logic                 emits;
   logic                 final_emit;
   logic                 out_free;
   logic                 emit_fire;
   logic                 consume;
   logic                 accept;
   logic [LenW-1:0]      rem_next;

   udpf_hdr u_hdr (
      .cfg            (cfg_ff),
      .payload_length (in_len_ff),
      .hdr_idx        (hdr_idx_ff),
      .hdr_byte       (hdr_data)
   );

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            RegSourceMac:       cfg_in.source_mac       = csr_wr_data[47:0];
            RegDestinationMac:  cfg_in.destination_mac  = csr_wr_data[47:0];
            RegSourceIp:        cfg_in.source_ip        = csr_wr_data[31:0];
            RegDestinationIp:   cfg_in.destination_ip   = csr_wr_data[31:0];
            RegSourcePort:      cfg_in.source_port      = csr_wr_data[15:0];
            RegDestinationPort: cfg_in.destination_port = csr_wr_data[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      len_bad    = (in_len_ff == '0) || (in_len_ff > LenW'(MaxPayload));
      good_start = in_start_ff && !len_bad;
      emits      = in_valid_ff && (in_start_ff || (!drop_ff && rem_ff != '0));
      hdr_byte   = good_start && (hdr_idx_ff < HdrIdxW'(HdrLen));
      final_emit = !good_start || (hdr_idx_ff == HdrIdxW'(HdrLen));
      out_free   = !out_valid_ff || rsp_tready;
      emit_fire  = emits && out_free;
      consume    = in_valid_ff && (!emits || (out_free && final_emit));
      req_tready = !in_valid_ff || consume;
      accept     = req_tvalid && req_tready;

      rem_next = in_start_ff ? (in_len_ff - LenW'(1)) : (rem_ff - LenW'(1));

      in_valid_in = accept || (in_valid_ff && !consume);
      in_byte_in  = accept ? req_tdata[7:0]  : in_byte_ff;
      in_len_in   = accept ? req_tdata[18:8] : in_len_ff;
      in_start_in = accept ? req_tuser       : in_start_ff;

      hdr_idx_in = hdr_idx_ff;
      if (emit_fire && good_start) begin
         hdr_idx_in = final_emit ? '0 : hdr_idx_ff + HdrIdxW'(1);
      end

      rem_in  = rem_ff;
      drop_in = drop_ff;
      if (consume && in_start_ff) begin
         drop_in = len_bad;
         rem_in  = len_bad ? '0 : rem_next;
      end else if (consume && emits) begin
         rem_in = rem_next;
      end

      // pick the result for this cycle: error marker, header byte or payload byte
      out_valid_in = emit_fire || (out_valid_ff && !rsp_tready);
      out_byte_in  = out_byte_ff;
      out_last_in  = out_last_ff;
      out_err_in   = out_err_ff;
      if (emit_fire) begin
         if (in_start_ff && len_bad) begin
            out_byte_in = 8'h00;
            out_last_in = 1'b1;
            out_err_in  = 1'b1;
         end else if (hdr_byte) begin
            out_byte_in = hdr_data;
            out_last_in = 1'b0;
            out_err_in  = 1'b0;
         end else begin
            out_byte_in = in_byte_ff;
            out_last_in = (rem_next == '0);
            out_err_in  = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.source_mac       <= SourceMacReset;
         cfg_ff.destination_mac  <= DestinationMacReset;
         cfg_ff.source_ip        <= SourceIpReset;
         cfg_ff.destination_ip   <= DestinationIpReset;
         cfg_ff.source_port      <= SourcePortReset;
         cfg_ff.destination_port <= DestinationPortReset;
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         hdr_idx_ff   <= '0;
         rem_ff       <= '0;
         drop_ff      <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         hdr_idx_ff   <= hdr_idx_in;
         rem_ff       <= rem_in;
         drop_ff      <= drop_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff  <= in_byte_in;
      in_start_ff <= in_start_in;
      in_len_ff   <= in_len_in;
      out_byte_ff <= out_byte_in;
      out_last_ff <= out_last_in;
      out_err_ff  <= out_err_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_byte_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tuser  = out_err_ff;

   // an error result always closes the frame
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast)
      else $error("length error result without last");

   // header walk only runs for a held start item
   assert property (@(posedge clock) disable iff (reset)
      hdr_idx_ff != '0 |-> in_valid_ff && in_start_ff && (hdr_idx_ff <= HdrIdxW'(HdrLen)))
      else $error("header index outside a start item");

   // no new item is taken in the middle of a header
   assert property (@(posedge clock) disable iff (reset)
      (hdr_idx_ff != '0) && (hdr_idx_ff < HdrIdxW'(HdrLen)) |-> !req_tready)
      else $error("input accepted during header insertion");

   // after a bad length nothing is pending for the dropped frame
   assert property (@(posedge clock) disable iff (reset)
      drop_ff |-> rem_ff == '0)
      else $error("payload count left while dropping");

endmodule

// ===== rtl/udpf_hdr.sv =====
// header byte generator: builds the 42-byte ethernet/ipv4/udp header and picks one byte
`timescale 1ns / 1ps

module udpf_hdr (
   input  udpf_pkg::cfg_type                 cfg,
   input  logic [udpf_pkg::LenW-1:0]         payload_length,
   input  logic [udpf_pkg::HdrIdxW-1:0]      hdr_idx,
   output logic [7:0]                        hdr_byte
);
   import udpf_pkg::*;

   logic [15:0]         ip_len;
   logic [15:0]         udp_len;
   logic [19:0]         csum_sum;
   logic [16:0]         csum_fold1;
   logic [15:0]         csum_fold2;
   logic [15:0]         csum;
   logic [HdrLen*8-1:0] hdr_vec;
   logic [HdrIdxW-1:0]  rev_idx;

   always_comb begin
      ip_len  = IpHdrBytes + 16'(payload_length);
      udp_len = UdpHdrBytes + 16'(payload_length);

      csum_sum = 20'({VerIhl, 8'h00}) + 20'(ip_len) + 20'({IpTtl, IpProtoUdp})
               + 20'(cfg.source_ip[31:16]) + 20'(cfg.source_ip[15:0])
               + 20'(cfg.destination_ip[31:16]) + 20'(cfg.destination_ip[15:0]);
      // two folds are enough: the first leaves at most a single carry
      csum_fold1 = 17'(csum_sum[15:0]) + 17'(csum_sum[19:16]);
      csum_fold2 = csum_fold1[15:0] + 16'(csum_fold1[16]);
      csum       = ~csum_fold2;

      hdr_vec = {cfg.destination_mac, cfg.source_mac, EtherTypeIpv4,
                 VerIhl, 8'h00, ip_len, 16'h0000, 16'h0000,
                 IpTtl, IpProtoUdp, csum,
                 cfg.source_ip, cfg.destination_ip,
                 cfg.source_port, cfg.destination_port,
                 udp_len, 16'h0000};

      // byte 0 sits in the top bits of the vector
      rev_idx = HdrIdxW'(HdrLen - 1) - hdr_idx;
      if (hdr_idx < HdrIdxW'(HdrLen)) begin
         hdr_byte = hdr_vec[{rev_idx, 3'b000} +: 8];
      end else begin
         hdr_byte = 8'h00;
      end
   end

endmodule
